/* sv/ate_pkg.sv */
// Package with the item types, command record and byte constants of the ANSI text row encoder.
`timescale 1ns / 1ps

package ate_pkg;

    localparam int ESC_MAX = 9;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_NBSP    = 8'hA0;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [1:0] UTF8_LEAD  = 2'b11;
    localparam logic [1:0] UTF8_CONT  = 2'b10;

    typedef struct packed {
        logic [7:0] character;
        logic [7:0] attribute;
        logic       row_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [ESC_MAX-1:0][7:0] esc_bytes;
        logic [3:0]              esc_len;
        logic [7:0]              chr0;
        logic [7:0]              chr1;
        logic                    chr_two;
        logic                    rst_en;
        logic                    nl_en;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

/* sv/ate_front.sv */
// Front end: holds the color register and current attribute, and turns each cell into a command.
`timescale 1ns / 1ps

module ate_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  ate_pkg::in_item_t in_item,
    input  logic             queue_full,
    output logic             push,
    output ate_pkg::cmd_t    cmd
);

    logic       color_enable_reg;
    logic       color_enable_next;
    logic [7:0] cur_attr_reg;
    logic [7:0] cur_attr_next;
    logic [7:0] attr_after;
    logic       sgr_en;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] ch;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        ch = in_item.character;
        fg = in_item.attribute[3:0];
        bg = in_item.attribute[7:4];
        sgr_en = color_enable_reg && (in_item.attribute != cur_attr_reg);
        attr_after = sgr_en ? in_item.attribute : cur_attr_reg;

        cmd = '0;
        for (int i = 0; i < ate_pkg::ESC_MAX; i++)
        begin
            cmd.esc_bytes[i] = ate_pkg::CH_M;
        end
        if (sgr_en)
        begin
            cmd.esc_bytes[0] = ate_pkg::CH_ESC;
            cmd.esc_bytes[1] = ate_pkg::CH_LBRACK;
            if (in_item.attribute == 8'd0)
            begin
                cmd.esc_bytes[2] = ate_pkg::CH_ZERO;
                cmd.esc_bytes[3] = ate_pkg::CH_M;
                cmd.esc_len = 4'd4;
            end
            else
            begin
                cmd.esc_bytes[2] = fg[3] ? ate_pkg::CH_NINE : ate_pkg::CH_THREE;
                cmd.esc_bytes[3] = ate_pkg::CH_ZERO + {5'd0, fg[2:0]};
                cmd.esc_bytes[4] = ate_pkg::CH_SEMI;
                if (bg[3])
                begin
                    cmd.esc_bytes[5] = ate_pkg::CH_ONE;
                    cmd.esc_bytes[6] = ate_pkg::CH_ZERO;
                    cmd.esc_bytes[7] = ate_pkg::CH_ZERO + {5'd0, bg[2:0]};
                    cmd.esc_bytes[8] = ate_pkg::CH_M;
                    cmd.esc_len = 4'd9;
                end
                else
                begin
                    cmd.esc_bytes[5] = ate_pkg::CH_FOUR;
                    cmd.esc_bytes[6] = ate_pkg::CH_ZERO + {5'd0, bg[2:0]};
                    cmd.esc_bytes[7] = ate_pkg::CH_M;
                    cmd.esc_len = 4'd8;
                end
            end
        end

        if (ch >= ate_pkg::CH_SPACE && ch < ate_pkg::CH_DEL)
        begin
            cmd.chr0 = ch;
            cmd.chr1 = ch;
            cmd.chr_two = 1'b0;
        end
        else if (ch >= ate_pkg::CH_NBSP)
        begin
            cmd.chr0 = {ate_pkg::UTF8_LEAD, 4'd0, ch[7:6]};
            cmd.chr1 = {ate_pkg::UTF8_CONT, ch[5:0]};
            cmd.chr_two = 1'b1;
        end
        else
        begin
            cmd.chr0 = ate_pkg::CH_SPACE;
            cmd.chr1 = ate_pkg::CH_SPACE;
            cmd.chr_two = 1'b0;
        end

        cmd.nl_en  = in_item.row_end;
        cmd.rst_en = in_item.row_end && color_enable_reg && (attr_after != 8'd0);

        color_enable_next = cfg_we ? cfg_data : color_enable_reg;
        cur_attr_next = cur_attr_reg;
        if (push)
        begin
            cur_attr_next = in_item.row_end ? 8'd0 : attr_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_enable_reg <= 1'b0;
            cur_attr_reg     <= 8'd0;
        end
        else
        begin
            color_enable_reg <= color_enable_next;
            cur_attr_reg     <= cur_attr_next;
        end
    end

endmodule

/* sv/ate_queue.sv */
// Two-entry command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module ate_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ate_pkg::queue_ctrl_t ctrl,
    input  ate_pkg::cmd_t        push_data,
    output logic                 full,
    output logic                 head_valid,
    output ate_pkg::cmd_t        head_data
);

    ate_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = ctrl.push && !full;
    assign do_pop     = ctrl.pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/ate_back.sv */
// Byte sequencer: puts head command bytes in the output reg, one per unstalled cycle.
`timescale 1ns / 1ps

module ate_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  ate_pkg::cmd_t        head_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ate_pkg::out_item_t   out_item
);

    typedef enum logic [1:0] {
        PH_ESC,
        PH_CHR,
        PH_RST,
        PH_NL
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    phase_t             eff_phase;
    logic [3:0]         idx_reg;
    logic [3:0]         idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ate_pkg::out_item_t out_item_reg;
    ate_pkg::out_item_t out_item_next;
    logic               emit;
    logic [7:0]         byte_sel;
    logic               phase_end;
    logic               done;
    phase_t             after;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign emit      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = emit && done;

    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == PH_ESC && head_data.esc_len == 4'd0)
        begin
            eff_phase = PH_CHR;
        end

        byte_sel  = ate_pkg::CH_NEWLINE;
        phase_end = 1'b1;
        after     = PH_NL;
        done      = 1'b0;
        unique case (eff_phase)
            PH_ESC:
            begin
                byte_sel  = head_data.esc_bytes[idx_reg];
                phase_end = (idx_reg == head_data.esc_len - 4'd1);
                after     = PH_CHR;
            end
            PH_CHR:
            begin
                byte_sel  = idx_reg[0] ? head_data.chr1 : head_data.chr0;
                phase_end = !head_data.chr_two || idx_reg[0];
                after     = head_data.rst_en ? PH_RST : PH_NL;
                done      = !head_data.rst_en && !head_data.nl_en;
            end
            PH_RST:
            begin
                unique case (idx_reg[1:0])
                    2'd0: byte_sel = ate_pkg::CH_ESC;
                    2'd1: byte_sel = ate_pkg::CH_LBRACK;
                    2'd2: byte_sel = ate_pkg::CH_ZERO;
                    2'd3: byte_sel = ate_pkg::CH_M;
                    default: byte_sel = ate_pkg::CH_M;
                endcase
                phase_end = (idx_reg[1:0] == 2'd3);
                after     = PH_NL;
            end
            PH_NL:
            begin
                byte_sel  = ate_pkg::CH_NEWLINE;
                phase_end = 1'b1;
                after     = PH_ESC;
                done      = 1'b1;
            end
            default:
            begin
                byte_sel  = ate_pkg::CH_NEWLINE;
                phase_end = 1'b1;
                after     = PH_ESC;
                done      = 1'b1;
            end
        endcase
        done = done && phase_end;

        phase_next     = phase_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_item_next.out_byte  = byte_sel;
            out_item_next.last_byte = done;
            if (done)
            begin
                phase_next = PH_ESC;
                idx_next   = 4'd0;
            end
            else if (phase_end)
            begin
                phase_next = after;
                idx_next   = 4'd0;
            end
            else
            begin
                phase_next = eff_phase;
                idx_next   = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ESC;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

/* sv/ansi_text_row_encoder.sv */
// Top level of the ANSI text row encoder.
`timescale 1ns / 1ps

// The block turns text cells into a terminal byte stream.
// Input channel in_valid/in_ready/in_item carries one cell per item: a Latin-1
// character, a color attribute and a row-end mark.
// Output channel out_valid/out_ready/out_item carries one byte per item, with
// last_byte set on the final byte that a cell causes.
// The color register is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A cell causes one to sixteen bytes, and the sequencer emits one byte per cycle
// while the receiver keeps up.
// Accepted cells are registered in the queue, and output bytes are registered.
// A two-entry command queue sits between the classifier and the sequencer, so
// cells are accepted while earlier cells are still being emitted.
// When the receiver stalls, the output register holds its byte, the sequencer
// stops, and input acceptance stops once the queue is full.
// Reset clears the color register, the current attribute, the queue and the
// output valid flag; no bytes are pending after reset.

module ansi_text_row_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ate_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ate_pkg::out_item_t   out_item
);

    ate_pkg::cmd_t        cmd;
    ate_pkg::cmd_t        head_data;
    ate_pkg::queue_ctrl_t qctrl;
    logic                 queue_full;
    logic                 head_valid;
    logic                 push;
    logic                 pop;

    assign qctrl.push = push;
    assign qctrl.pop  = pop;

    ate_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (cmd)
    );

    ate_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (qctrl),
        .push_data  (cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ate_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
